// ===== rtl/core/normalized_window_convolution_assert.svh =====
// assertion macros shared by the checker
`ifndef NORMALIZED_WINDOW_CONVOLUTION_ASSERT_SVH
`define NORMALIZED_WINDOW_CONVOLUTION_ASSERT_SVH

// condition holds in the same cycle
`define NWC_ASSERT_SAME(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// trigger implies a property in the cycle after it
`define NWC_ASSERT_NEXT(lbl, trig, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/core/nwc_pkg.sv =====
`timescale 1ns / 1ps
package nwc_pkg;
   localparam int PIXEL_W    = 8;
   localparam int COEF_W     = 8;
   localparam int COEF_BYTES = 32;
   localparam int DIM_W      = 11;
   localparam int KSIDE_W    = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int FILTERED_W = 21;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_KERNEL_SIDE  = 3'd0,
      CSR_IMAGE_WIDTH  = 3'd1,
      CSR_IMAGE_HEIGHT = 3'd2,
      CSR_COEF_WORD_0  = 3'd3,
      CSR_COEF_WORD_1  = 3'd4,
      CSR_COEF_WORD_2  = 3'd5,
      CSR_COEF_WORD_3  = 3'd6
   } csr_index_type;
endpackage

// ===== rtl/core/nwc_ram.sv =====
`timescale 1ns / 1ps
module nwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== rtl/core/normalized_window_convolution.sv =====
`timescale 1ns / 1ps
// Normalized K x K convolution over a raster pixel stream. Each pixel is written into a
// line store of MAX_KERNEL rows; when it completes a window that lies wholly inside the
// image, the K*K window pixels are read back one per cycle through the single read port
// of that memory, multiplied by the signed coefficients and summed, and the sum is then
// divided by the coefficient sum in a bit-serial divider, one quotient bit per cycle.
// One item is in work at a time. A pixel with no result passes S_MOD and S_WRITE; a
// pixel with a result goes on through S_READ, S_DRAIN, S_SIGN, S_DIV, S_FIN and S_OUT,
// where it waits for rsp_tready; ACC_W is 22 for the default MAX_KERNEL of 5. A zero
// coefficient sum skips the divider, gives 0 and raises divide_by_zero on rsp_tuser.
// The line store needs no clearing after reset.
module normalized_window_convolution #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_KERNEL = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [nwc_pkg::REQ_DATA_W-1:0]    req_tdata,   // pixel
   input  logic                              req_tuser,   // frame_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [nwc_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // filtered, zero pad
   output logic                              rsp_tlast,
   output logic                              rsp_tuser,   // divide_by_zero
   input  logic                              csr_wen,
   input  logic [nwc_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [nwc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import nwc_pkg::*;

   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int SW      = $clog2(MAX_KERNEL);
   localparam int KW      = $clog2(MAX_KERNEL + 1);
   localparam int NW      = $clog2(MAX_KERNEL * MAX_KERNEL);
   localparam int ACC_W   = PIXEL_W + COEF_W + 1 + NW;
   localparam int CSUM_W  = COEF_W + NW;
   localparam int DC_W    = $clog2(ACC_W + 1);
   localparam int DEPTH   = MAX_KERNEL << CW;
   localparam int AW      = $clog2(DEPTH);
   localparam int RECIP_S = 24;
   localparam int RECIP   = ((1 << RECIP_S) + MAX_KERNEL - 1) / MAX_KERNEL;
   localparam int PROD_W  = DIM_W + RECIP_S;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_MOD   = 9'b000000010,
      S_WRITE = 9'b000000100,
      S_READ  = 9'b000001000,
      S_DRAIN = 9'b000010000,
      S_SIGN  = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_FIN   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [KSIDE_W-1:0]    kside_ff;
   logic [DIM_W-1:0]      width_ff, height_ff;
   logic [CSR_DATA_W-1:0] coef0_ff, coef1_ff, coef2_ff;
   logic [COEF_W-1:0]     coef3_ff;

   logic [CW-1:0]     col_cnt_ff, col_cnt_in;
   logic [DIM_W-1:0]  row_cnt_ff, row_cnt_in;

   logic [PIXEL_W-1:0] pix_ff;
   logic [CW-1:0]      col_ff;
   logic [DIM_W-1:0]   row_ff;
   logic [KW-1:0]      k_ff;
   logic               last_ff, win_ok_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SW-1:0]      base_ff;

   logic [KW-1:0]     r_ff, c_ff;
   logic [NW-1:0]     n_ff;
   logic signed [COEF_W-1:0] mac_coef_ff;
   logic              mac_v_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [CSUM_W-1:0] csum_ff;

   logic [ACC_W-1:0]  num_ff;
   logic [CSUM_W-1:0] den_ff, rem_ff;
   logic [DC_W-1:0]   dcnt_ff;
   logic              neg_ff;

   logic signed [FILTERED_W-1:0] filtered_ff;
   logic              dz_ff;

   logic [KW-1:0]    k_eff;
   logic [WW-1:0]    w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [CW-1:0]    col_s, col_c;
   logic [DIM_W-1:0] row_s, row_c;
   logic             last_c, win_ok_c;
   logic             req_acc;

   logic [DIM_W-1:0] quot;
   logic [SW-1:0]    base_c;
   logic [SW:0]      slot_sum;
   logic [SW-1:0]    slot_r;
   logic [CW-1:0]    col_r;
   logic [COEF_BYTES*COEF_W-1:0] coef_all;
   logic [4:0]       coef_idx;
   logic signed [COEF_W-1:0] coef_c;
   logic             last_issue;

   logic signed [PIXEL_W+COEF_W:0] mprod;
   logic [CSUM_W:0]  rem_sh;
   logic             ge;
   logic signed [ACC_W:0] qs;

   logic             ram_wen;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [PIXEL_W-1:0] ram_rdata;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         kside_ff  <= KSIDE_W'(3);
         width_ff  <= DIM_W'(1024);
         height_ff <= DIM_W'(1024);
         coef0_ff  <= '0;
         coef1_ff  <= '0;
         coef2_ff  <= '0;
         coef3_ff  <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_KERNEL_SIDE:  kside_ff  <= csr_wdata[KSIDE_W-1:0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_COEF_WORD_0:  coef0_ff  <= csr_wdata;
            CSR_COEF_WORD_1:  coef1_ff  <= csr_wdata;
            CSR_COEF_WORD_2:  coef2_ff  <= csr_wdata;
            CSR_COEF_WORD_3:  coef3_ff  <= csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // position of the incoming pixel
   always_comb begin
      if (kside_ff == '0) begin
         k_eff = KW'(1);
      end else if (int'(kside_ff) > MAX_KERNEL) begin
         k_eff = KW'(MAX_KERNEL);
      end else begin
         k_eff = KW'(kside_ff);
      end
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      h_eff = (height_ff == '0) ? DIM_W'(1) : height_ff;

      col_s = req_tuser ? '0 : col_cnt_ff;
      row_s = req_tuser ? '0 : row_cnt_ff;
      col_c = (WW'(col_s) >= w_eff) ? CW'(w_eff - WW'(1)) : col_s;
      row_c = (row_s >= h_eff) ? (h_eff - DIM_W'(1)) : row_s;
      last_c = (row_c == h_eff - DIM_W'(1)) && (WW'(col_c) == w_eff - WW'(1));
      win_ok_c = ((DIM_W+1)'(row_c) + (DIM_W+1)'(1) >= (DIM_W+1)'(k_eff)) &&
                 ((CW+1)'(col_c) + (CW+1)'(1) >= (CW+1)'(k_eff));

      if ((WW+1)'(col_c) + (WW+1)'(1) < (WW+1)'(w_eff)) begin
         col_cnt_in = col_c + CW'(1);
         row_cnt_in = row_c;
      end else begin
         col_cnt_in = '0;
         row_cnt_in = last_c ? '0 : row_c + DIM_W'(1);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // row modulo line count, and window addressing
   always_comb begin
      quot     = DIM_W'(prod_ff >> RECIP_S);
      base_c   = SW'(row_ff - DIM_W'(quot * DIM_W'(MAX_KERNEL)));
      slot_sum = (SW+1)'(int'(base_ff) + MAX_KERNEL + 1 - int'(k_ff) + int'(r_ff));
      slot_r   = (int'(slot_sum) >= MAX_KERNEL) ? SW'(int'(slot_sum) - MAX_KERNEL)
                                                : SW'(slot_sum);
      col_r    = CW'(int'(col_ff) + 1 - int'(k_ff) + int'(c_ff));
      coef_all = {{(COEF_BYTES*COEF_W - 3*CSR_DATA_W - COEF_W){1'b0}},
                  coef3_ff, coef2_ff, coef1_ff, coef0_ff};
      coef_idx = 5'(n_ff);
      if (int'(n_ff) < COEF_BYTES) begin
         coef_c = $signed(coef_all[coef_idx*COEF_W +: COEF_W]);
      end else begin
         coef_c = '0;
      end
      last_issue = (r_ff == k_ff - KW'(1)) && (c_ff == k_ff - KW'(1));
   end

   assign ram_wen   = (state_ff == S_WRITE);
   assign ram_waddr = AW'({base_c, col_ff});
   assign ram_raddr = AW'({slot_r, col_r});

   nwc_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock (clock),
      .wen   (ram_wen),
      .waddr (ram_waddr),
      .wdata (pix_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // arithmetic
   always_comb begin
      mprod  = mac_coef_ff * $signed({1'b0, ram_rdata});
      rem_sh = {rem_ff, num_ff[ACC_W-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      qs     = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_acc) state_in = S_MOD;
         S_MOD:   state_in = S_WRITE;
         S_WRITE: state_in = win_ok_ff ? S_READ : S_IDLE;
         S_READ:  if (last_issue) state_in = S_DRAIN;
         S_DRAIN: state_in = S_SIGN;
         S_SIGN:  state_in = (csum_ff == '0) ? S_OUT : S_DIV;
         S_DIV:   if (dcnt_ff == DC_W'(1)) state_in = S_FIN;
         S_FIN:   state_in = S_OUT;
         S_OUT:   if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         mac_v_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_acc) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
         end
         mac_v_ff <= (state_ff == S_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         pix_ff    <= req_tdata[PIXEL_W-1:0];
         col_ff    <= col_c;
         row_ff    <= row_c;
         k_ff      <= k_eff;
         last_ff   <= last_c;
         win_ok_ff <= win_ok_c;
      end
      if (state_ff == S_MOD) begin
         prod_ff <= PROD_W'(row_ff) * PROD_W'(RECIP);
      end
      if (state_ff == S_WRITE) begin
         base_ff <= base_c;
         r_ff    <= '0;
         c_ff    <= '0;
         n_ff    <= '0;
         acc_ff  <= '0;
         csum_ff <= '0;
      end
      if (state_ff == S_READ) begin
         mac_coef_ff <= coef_c;
         csum_ff     <= csum_ff + CSUM_W'(coef_c);
         n_ff        <= n_ff + NW'(1);
         if (c_ff == k_ff - KW'(1)) begin
            c_ff <= '0;
            r_ff <= r_ff + KW'(1);
         end else begin
            c_ff <= c_ff + KW'(1);
         end
      end
      if (mac_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(mprod);
      end
      if (state_ff == S_SIGN) begin
         num_ff  <= acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
         den_ff  <= csum_ff[CSUM_W-1] ? CSUM_W'(-csum_ff) : CSUM_W'(csum_ff);
         rem_ff  <= '0;
         dcnt_ff <= DC_W'(ACC_W);
         neg_ff  <= acc_ff[ACC_W-1] ^ csum_ff[CSUM_W-1];
         dz_ff   <= (csum_ff == '0);
         filtered_ff <= '0;
      end
      if (state_ff == S_DIV) begin
         rem_ff  <= ge ? CSUM_W'(rem_sh - {1'b0, den_ff}) : CSUM_W'(rem_sh);
         num_ff  <= {num_ff[ACC_W-2:0], ge};
         dcnt_ff <= dcnt_ff - DC_W'(1);
      end
      if (state_ff == S_FIN) begin
         filtered_ff <= FILTERED_W'(qs);
      end
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {{(RSP_DATA_W-FILTERED_W){1'b0}}, filtered_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = dz_ff;
endmodule

// ===== rtl/core/nwc_checker.sv =====
`timescale 1ns / 1ps
`include "normalized_window_convolution_assert.svh"
module nwc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [nwc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           rsp_tuser
);
   import nwc_pkg::*;

   `NWC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "result item changed while stalled")
   `NWC_ASSERT_SAME(a_dz_zero, !(rsp_tvalid && rsp_tuser) || (rsp_tdata[FILTERED_W-1:0] == '0), "divide by zero result not zero")
   `NWC_ASSERT_SAME(a_one_item, !(rsp_tvalid && req_tready), "input taken while result pending")
   `NWC_ASSERT_NEXT(a_busy, req_tvalid && req_tready, !req_tready && !rsp_tvalid, "block not busy after taking an item")
endmodule

bind normalized_window_convolution nwc_checker u_nwc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
